>>> rtl/mcw_pkg.sv
`timescale 1ns / 1ps

package mcw_pkg;

  // Field widths of the stream words
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned TMO_W    = 16;
  localparam int unsigned ID_W     = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RELOAD_W = 12;

  // Client counter holds 0..31
  localparam int unsigned CNT_W = 5;

  // Packed word widths, rounded up to whole bytes
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // timeout / 6 as (timeout * 43691) >> 18, exact for all 16-bit inputs
  localparam int unsigned DIV6_MUL_W = 17;
  localparam int unsigned DIV6_SHIFT = 18;
  localparam logic [DIV6_MUL_W-1:0] DIV6_MUL = 17'd43691;
  localparam int unsigned PROD_W = TMO_W + DIV6_MUL_W;
  localparam int unsigned QUOT_W = PROD_W - DIV6_SHIFT;

  localparam logic [RELOAD_W-1:0] RELOAD_RST = 12'hFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE  = 2'd0,
    KIND_CHECKIN = 2'd1,
    KIND_TICK    = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_BAD_ID = 2'd2
  } status_t;

endpackage

>>> rtl/multi_client_watchdog_unit.sv
`timescale 1ns / 1ps
// Flow: a word accepted into the input register is processed into the result
//   register, which drives out_*; a stall of the result register holds it back.
// Throughput: one word per cycle; the input register and the result register
//   both advance whenever the result register is empty or being taken.
// Reset (rst_n low, synchronous): both stages empty, no clients, counter and
//   reload value at 4095, watchdog stopped, expiry clear.
module multi_client_watchdog_unit #(
  parameter int unsigned MAX_CLIENTS  = 31,
  parameter int unsigned RELOAD_LIMIT = 4095
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // slave side
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mcw_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] req_timeout, [20:16] client_id
  input  logic [mcw_pkg::KIND_W-1:0]     in_tuser,   // [1:0] kind
  // master side
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mcw_pkg::OUT_DATA_W-1:0] out_tdata   // [1:0] status, [6:2] new_id,
                                                     // [7] kicked, [8] expired,
                                                     // [20:9] reload_cur
);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                        in_valid_r;
  logic [mcw_pkg::KIND_W-1:0]  in_kind_r;
  logic [mcw_pkg::TMO_W-1:0]   in_tmo_r;
  logic [mcw_pkg::ID_W-1:0]    in_id_r;

  logic out_valid_r;
  logic stall;
  logic fire;   // input register holds a word that is processed this cycle

  assign stall     = out_valid_r && !out_tready;
  assign fire      = in_valid_r && !stall;
  assign in_tready = !in_valid_r || !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_kind_r <= in_tuser;
      in_tmo_r  <= in_tdata[mcw_pkg::TMO_W-1:0];
      in_id_r   <= in_tdata[mcw_pkg::TMO_W +: mcw_pkg::ID_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog state
  // ---------------------------------------------------------------------------
  logic [MAX_CLIENTS-1:0]        pending_mask_r, pending_mask_nxt;
  logic [mcw_pkg::CNT_W-1:0]     client_count_r, client_count_nxt;
  logic [mcw_pkg::TMO_W-1:0]     largest_tmo_r, largest_tmo_nxt;
  logic [mcw_pkg::RELOAD_W-1:0]  reload_word_r, reload_word_nxt;
  logic [mcw_pkg::RELOAD_W-1:0]  down_cnt_r, down_cnt_nxt;
  logic                          running_r, running_nxt;
  logic                          fired_r, fired_nxt;

  // Decode helpers: one-hot of the check-in id, one-hot of the next free slot,
  // and the set of registered clients.
  logic [MAX_CLIENTS-1:0] id_onehot;
  logic [MAX_CLIENTS-1:0] slot_onehot;
  logic [MAX_CLIENTS-1:0] valid_mask;
  logic [MAX_CLIENTS-1:0] checkin_mask;

  always_comb begin
    for (int i = 0; i < MAX_CLIENTS; i++) begin
      id_onehot[i]   = (in_id_r == mcw_pkg::ID_W'(i));
      slot_onehot[i] = (client_count_r == mcw_pkg::CNT_W'(i));
      valid_mask[i]  = (mcw_pkg::CNT_W'(i) < client_count_r);
    end
  end

  assign checkin_mask = pending_mask_r | id_onehot;

  // Reload value from the requested timeout: min(timeout / 6, RELOAD_LIMIT)
  logic [mcw_pkg::PROD_W-1:0]    div_prod;
  logic [mcw_pkg::QUOT_W-1:0]    div_quot;
  logic [mcw_pkg::RELOAD_W-1:0]  new_reload;

  assign div_prod = mcw_pkg::PROD_W'(in_tmo_r) * mcw_pkg::PROD_W'(mcw_pkg::DIV6_MUL);
  assign div_quot = div_prod[mcw_pkg::PROD_W-1:mcw_pkg::DIV6_SHIFT];
  assign new_reload = (div_quot > mcw_pkg::QUOT_W'(RELOAD_LIMIT))
                    ? mcw_pkg::RELOAD_W'(RELOAD_LIMIT)
                    : div_quot[mcw_pkg::RELOAD_W-1:0];

  logic                       table_full;
  logic                       id_ok;
  mcw_pkg::status_t           status;
  logic [mcw_pkg::ID_W-1:0]   new_id;
  logic                       kicked;

  assign table_full = (client_count_r >= mcw_pkg::CNT_W'(MAX_CLIENTS));
  assign id_ok      = (mcw_pkg::CNT_W'(in_id_r) < client_count_r);

  always_comb begin
    pending_mask_nxt = pending_mask_r;
    client_count_nxt = client_count_r;
    largest_tmo_nxt  = largest_tmo_r;
    reload_word_nxt  = reload_word_r;
    down_cnt_nxt     = down_cnt_r;
    running_nxt      = running_r;
    fired_nxt        = fired_r;
    status           = mcw_pkg::ST_OK;
    new_id           = '0;
    kicked           = 1'b0;

    case (mcw_pkg::kind_t'(in_kind_r))
      mcw_pkg::KIND_CREATE: begin
        if (in_tmo_r == '0 || table_full) begin
          status = mcw_pkg::ST_REJECT;
        end else begin
          new_id           = mcw_pkg::ID_W'(client_count_r);
          pending_mask_nxt = pending_mask_r | slot_onehot;
          client_count_nxt = client_count_r + mcw_pkg::CNT_W'(1);
          // Only a new largest timeout moves the reload value and (re)starts
          if (in_tmo_r > largest_tmo_r) begin
            reload_word_nxt = new_reload;
            down_cnt_nxt    = new_reload;
            running_nxt     = 1'b1;
            largest_tmo_nxt = in_tmo_r;
          end
        end
      end
      mcw_pkg::KIND_CHECKIN: begin
        if (!id_ok) begin
          status = mcw_pkg::ST_BAD_ID;
        end else if ((checkin_mask & valid_mask) == valid_mask) begin
          // Last outstanding client: kick, even if stopped or expired
          down_cnt_nxt     = reload_word_r;
          pending_mask_nxt = '0;
          kicked           = 1'b1;
        end else begin
          pending_mask_nxt = checkin_mask;
        end
      end
      mcw_pkg::KIND_TICK: begin
        if (running_r && !fired_r) begin
          // Expires on the tick that reaches zero, or at once if already zero
          if (down_cnt_r <= mcw_pkg::RELOAD_W'(1)) begin
            fired_nxt = 1'b1;
          end
          if (down_cnt_r != '0) begin
            down_cnt_nxt = down_cnt_r - mcw_pkg::RELOAD_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_mask_r <= '0;
      client_count_r <= '0;
      largest_tmo_r  <= '0;
      reload_word_r  <= mcw_pkg::RELOAD_RST;
      down_cnt_r     <= mcw_pkg::RELOAD_RST;
      running_r      <= 1'b0;
      fired_r        <= 1'b0;
    end else if (fire) begin
      pending_mask_r <= pending_mask_nxt;
      client_count_r <= client_count_nxt;
      largest_tmo_r  <= largest_tmo_nxt;
      reload_word_r  <= reload_word_nxt;
      down_cnt_r     <= down_cnt_nxt;
      running_r      <= running_nxt;
      fired_r        <= fired_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [mcw_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [mcw_pkg::OUT_DATA_W-1:0] out_data_nxt;

  assign out_data_nxt = mcw_pkg::OUT_DATA_W'({reload_word_nxt, fired_nxt, kicked,
                                              new_id, status});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!stall) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fired_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fired_r |=> fired_r)
    else $error("expiry flag cleared after being set");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    client_count_r <= mcw_pkg::CNT_W'(MAX_CLIENTS))
    else $error("client count beyond table size");

  a_mask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_mask_r & ~valid_mask) == '0)
    else $error("pending bit set for an unregistered client");

  a_kick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && kicked |=> pending_mask_r == '0 && down_cnt_r == reload_word_r)
    else $error("kick did not clear mask and reload counter");

  a_reload_limit: assert property (@(posedge clk) disable iff (!rst_n)
    $changed(reload_word_r) |-> reload_word_r <= mcw_pkg::RELOAD_W'(RELOAD_LIMIT))
    else $error("reload value above limit");

endmodule

>>> dv/mcw_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the watchdog, predicts every result word from the
// accepted input words and compares the two, oldest first.
module mcw_checker #(
  parameter int unsigned MAX_CLIENTS  = 31,
  parameter int unsigned RELOAD_LIMIT = 4095
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [mcw_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [mcw_pkg::KIND_W-1:0]     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [mcw_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             fail_count,
  output int                             outstanding,
  output int                             n_results,
  output int                             n_kicks,
  output int                             n_rejects,
  output int                             n_bad_ids,
  output logic                           saw_expiry
);

  localparam int unsigned TIMEOUT_DIV = 6;

  // result word, lowest field last
  typedef struct packed {
    logic [mcw_pkg::RELOAD_W-1:0] reload_cur;
    logic                         expired;
    logic                         kicked;
    logic [mcw_pkg::ID_W-1:0]     new_id;
    mcw_pkg::status_t             status;
  } wd_result_t;

  wd_result_t expected_q[$];

  // watchdog state
  logic [MAX_CLIENTS-1:0]        checked_in;
  logic [mcw_pkg::CNT_W-1:0]     n_reg;
  logic [mcw_pkg::TMO_W-1:0]     top_tmo;
  logic [mcw_pkg::RELOAD_W-1:0]  reload_val;
  logic [mcw_pkg::RELOAD_W-1:0]  countdown;
  logic                          armed;
  logic                          fired;

  function automatic wd_result_t wd_predict(logic [mcw_pkg::KIND_W-1:0] kind,
                                            logic [mcw_pkg::TMO_W-1:0] tmo,
                                            logic [mcw_pkg::ID_W-1:0] id);
    wd_result_t  r;
    logic [31:0] full_set;
    int unsigned q;
    r = '0;
    r.status = mcw_pkg::ST_OK;
    case (kind)
      mcw_pkg::KIND_CREATE: begin
        if (tmo == 0 || n_reg >= MAX_CLIENTS) begin
          r.status = mcw_pkg::ST_REJECT;
        end else begin
          r.new_id = n_reg;
          checked_in[n_reg] = 1'b1;
          n_reg = n_reg + 1'b1;
          if (tmo > top_tmo) begin
            q = tmo / TIMEOUT_DIV;
            reload_val = (q > RELOAD_LIMIT) ? mcw_pkg::RELOAD_W'(RELOAD_LIMIT)
                                            : mcw_pkg::RELOAD_W'(q);
            countdown = reload_val;
            armed = 1'b1;
            top_tmo = tmo;
          end
        end
      end
      mcw_pkg::KIND_CHECKIN: begin
        if (id >= n_reg) begin
          r.status = mcw_pkg::ST_BAD_ID;
        end else begin
          checked_in[id] = 1'b1;
          full_set = (32'd1 << n_reg) - 32'd1;
          if ((checked_in & full_set[MAX_CLIENTS-1:0]) == full_set[MAX_CLIENTS-1:0]) begin
            countdown = reload_val;
            checked_in = '0;
            r.kicked = 1'b1;
          end
        end
      end
      mcw_pkg::KIND_TICK: begin
        if (armed && !fired) begin
          if (countdown == 0) begin
            fired = 1'b1;
          end else begin
            countdown = countdown - 1'b1;
            if (countdown == 0) fired = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.expired = fired;
    r.reload_cur = reload_val;
    return r;
  endfunction

  function automatic int field_diff(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t  %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    wd_result_t want;
    wd_result_t got;
    int         errs;
    if (!rst_n) begin
      checked_in = '0;
      n_reg      = '0;
      top_tmo    = '0;
      reload_val = mcw_pkg::RELOAD_RST;
      countdown  = mcw_pkg::RELOAD_RST;
      armed      = 1'b0;
      fired      = 1'b0;
      expected_q.delete();
      fail_count = 0;
      n_results  = 0;
      n_kicks    = 0;
      n_rejects  = 0;
      n_bad_ids  = 0;
      saw_expiry = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = wd_result_t'(out_tdata[$bits(wd_result_t)-1:0]);
        if (expected_q.size() == 0) begin
          $display("%0t  result word %h arrived, none expected", $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          errs = field_diff("status", want.status, got.status)
               + field_diff("new_id", want.new_id, got.new_id)
               + field_diff("kicked", want.kicked, got.kicked)
               + field_diff("expired", want.expired, got.expired)
               + field_diff("reload_cur", want.reload_cur, got.reload_cur);
          if (errs != 0) fail_count++;
        end
        n_results++;
        if (got.kicked) n_kicks++;
        if (got.status == mcw_pkg::ST_REJECT) n_rejects++;
        if (got.status == mcw_pkg::ST_BAD_ID) n_bad_ids++;
        if (got.expired) saw_expiry = 1'b1;
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(wd_predict(in_tuser, in_tdata[mcw_pkg::TMO_W-1:0],
                             in_tdata[mcw_pkg::TMO_W+mcw_pkg::ID_W-1:mcw_pkg::TMO_W]));
    end
    outstanding <= expected_q.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the multi-client watchdog. All prediction and
// comparison lives in mcw_checker; this module only makes words, paces both
// sides of the stream and reads the checker's counts at the end.
module tb;

  localparam int unsigned MAX_CLIENTS  = 31;
  localparam int unsigned RELOAD_LIMIT = 4095;
  localparam int unsigned TIMEOUT_DIV  = 6;

  // kind code the block leaves unused
  localparam logic [mcw_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  // random creates stop here so the clipped-reload create still fits later
  localparam int RANDOM_CLIENT_CAP = 28;
  localparam int PHASE_WORDS       = 350;
  localparam int HOLD_CYCLES       = 200;

  // idling per phase: none, sender only, receiver only, both
  localparam int SRC_IDLE   [4] = '{0, 65, 0, 34};
  localparam int SINK_STALL [4] = '{0, 0, 65, 34};

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [mcw_pkg::IN_DATA_W-1:0]  in_tdata   = '0;  // [15:0] req_timeout, [20:16] client_id
  logic [mcw_pkg::KIND_W-1:0]     in_tuser   = '0;  // [1:0] kind
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [mcw_pkg::OUT_DATA_W-1:0] out_tdata;        // [1:0] status, [6:2] new_id,
                                                    // [7] kicked, [8] expired,
                                                    // [20:9] reload_cur

  int   fail_count, outstanding, n_results, n_kicks, n_rejects, n_bad_ids;
  logic saw_expiry;

  // pacing knobs, owned by the stimulus process
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int holds_asked    = 0;

  // owned by the receiver process
  int hold_left  = 0;
  int holds_done = 0;

  // rough view of the block, kept only to steer stimulus (never checked)
  int          words_sent  = 0;
  int          n_clients   = 0;
  int unsigned largest     = 0;
  int          reload_est  = 0;
  int          ticks_since = 0;   // ticks since counter last got reload_est
  bit          early_zero;        // this run expires through a zero reload

  multi_client_watchdog_unit #(
    .MAX_CLIENTS (MAX_CLIENTS),
    .RELOAD_LIMIT(RELOAD_LIMIT)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  mcw_checker #(
    .MAX_CLIENTS (MAX_CLIENTS),
    .RELOAD_LIMIT(RELOAD_LIMIT)
  ) u_wd_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .outstanding(outstanding),
    .n_results  (n_results),
    .n_kicks    (n_kicks),
    .n_rejects  (n_rejects),
    .n_bad_ids  (n_bad_ids),
    .saw_expiry (saw_expiry)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks
  // for one. The hold is counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES - 1;
      holds_done <= holds_asked;
    end else begin
      out_tready <= ($urandom_range(1, 100) > sink_stall_pct);
    end
  end

  // Offer one word, with a random gap ahead of it, and return at the edge
  // where it is taken. tvalid stays high so back-to-back words need no gap.
  task automatic push_word(input logic [mcw_pkg::KIND_W-1:0] kind,
                           input logic [mcw_pkg::TMO_W-1:0] tmo,
                           input logic [mcw_pkg::ID_W-1:0] id);
    while (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= mcw_pkg::IN_DATA_W'({id, tmo});
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic send_tick();
    push_word(mcw_pkg::KIND_TICK, mcw_pkg::TMO_W'($urandom), mcw_pkg::ID_W'($urandom));
    ticks_since++;
  endtask

  // Create; a larger timeout reloads and restarts the counter.
  task automatic send_create(input logic [mcw_pkg::TMO_W-1:0] tmo);
    push_word(mcw_pkg::KIND_CREATE, tmo, mcw_pkg::ID_W'($urandom));
    if (tmo != 0 && n_clients < MAX_CLIENTS) begin
      n_clients++;
      if (tmo > largest) begin
        largest     = tmo;
        reload_est  = (largest / TIMEOUT_DIV > RELOAD_LIMIT) ? RELOAD_LIMIT
                                                             : largest / TIMEOUT_DIV;
        ticks_since = 0;
      end
    end
  endtask

  // Every registered client checks in once, shuffled, with the odd stray id
  // mixed in. The mask fills at least once along the way, so the round ends
  // with a kick and no tick after it: counter sits at the reload value.
  task automatic send_round();
    int ids [MAX_CLIENTS];
    int j, t, k;
    for (k = 0; k < n_clients; k++) ids[k] = k;
    for (k = n_clients - 1; k > 0; k--) begin
      j      = $urandom_range(0, k);
      t      = ids[k];
      ids[k] = ids[j];
      ids[j] = t;
    end
    for (k = 0; k < n_clients; k++) begin
      if ($urandom_range(0, 15) == 0)
        push_word(mcw_pkg::KIND_CHECKIN, mcw_pkg::TMO_W'($urandom),
                  mcw_pkg::ID_W'($urandom));
      push_word(mcw_pkg::KIND_CHECKIN, mcw_pkg::TMO_W'($urandom), mcw_pkg::ID_W'(ids[k]));
    end
    ticks_since = 0;
  endtask

  // Drop tvalid and wait until every expected result is back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int phase, phase_end, pick, budget, burst, k, w;

    // expiry is sticky and reset comes only once, so each run reaches zero
    // one way: a zero reload (about a quarter of seeds) or counting down
    early_zero = ($urandom_range(0, 3) == 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed words, no idling ----
    push_word(KIND_UNUSED, 16'hFFFF, 5'd31);                // unused kind, all ones
    push_word(mcw_pkg::KIND_CHECKIN, 16'h0000, 5'd0);       // check-in with no clients
    send_tick();                                            // tick before the counter runs
    send_create(16'd0);                                     // zero timeout rejected
    send_create(early_zero ? mcw_pkg::TMO_W'($urandom_range(1, 5)) : 16'd60);
    send_tick();                                            // zero reload: expires here
    send_create(16'd12);                                    // smaller timeout (normal run)
    send_create(16'd60);                                    // equal timeout in a normal run, no reload
    push_word(mcw_pkg::KIND_CHECKIN, 16'h1234, 5'd31);      // id past the last table slot
    push_word(mcw_pkg::KIND_CHECKIN, 16'h0000, 5'd3);       // id == client count
    // creates marked all three checked in: the first check-in kicks at once
    push_word(mcw_pkg::KIND_CHECKIN, 16'h0000, 5'd1);
    push_word(mcw_pkg::KIND_CHECKIN, 16'h0000, 5'd0);
    push_word(mcw_pkg::KIND_CHECKIN, 16'h0000, 5'd0);       // repeat check-in
    push_word(mcw_pkg::KIND_CHECKIN, 16'h0000, 5'd2);
    push_word(mcw_pkg::KIND_CHECKIN, 16'h0000, 5'd1);       // completes the set: kick
    ticks_since = 0;
    repeat (3) send_tick();

    // ---- random words over the four idling phases ----
    for (phase = 0; phase < 4; phase++) begin
      drain();                                      // sender waits for all results
      src_idle_pct   = SRC_IDLE[phase];
      sink_stall_pct = SINK_STALL[phase];
      // long receiver hold while words keep coming: block fills and stalls
      if (phase == 0 || phase == 3) holds_asked++;
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        pick   = $urandom_range(1, 100);
        budget = reload_est - 1 - ticks_since;      // ticks left before zero
        if (pick <= 8 && n_clients < RANDOM_CLIENT_CAP) begin
          send_create(($urandom_range(0, 3) == 0)
                      ? mcw_pkg::TMO_W'($urandom_range(1, 5))
                      : mcw_pkg::TMO_W'($urandom_range(6, 600)));
        end else if (pick <= 40) begin
          send_round();
        end else if (pick <= 88) begin
          if (early_zero) burst = $urandom_range(1, 20);
          else if (budget <= 0) burst = 0;
          else if ($urandom_range(0, 4) == 0) burst = budget;   // run down to one
          else burst = $urandom_range(1, (budget < 30) ? budget : 30);
          if (burst == 0) send_round();
          else repeat (burst) send_tick();
        end else begin
          case ($urandom_range(0, 2))
            0:       push_word(KIND_UNUSED, mcw_pkg::TMO_W'($urandom),
                               mcw_pkg::ID_W'($urandom));
            1:       push_word(mcw_pkg::KIND_CHECKIN, mcw_pkg::TMO_W'($urandom),
                               mcw_pkg::ID_W'($urandom));
            default: send_create(16'd0);
          endcase
        end
      end
    end

    // ---- wrap-up: expiry, life after it, clipped reload, full table ----
    send_round();                                   // counter back at reload_est
    if (early_zero) repeat (3) send_tick();
    else repeat (reload_est + 2) send_tick();       // reach zero, then two more
    send_round();                                   // kick after expiry
    send_create(16'hFFFF);                          // reload clipped to the limit
    while (n_clients < MAX_CLIENTS)
      send_create(mcw_pkg::TMO_W'($urandom_range(1, 16'hFFFF)));
    send_create(16'd100);                           // table full
    send_create(16'hFFFF);
    push_word(mcw_pkg::KIND_CHECKIN, 16'h0000, 5'd30);   // last valid id
    push_word(mcw_pkg::KIND_CHECKIN, 16'h0000, 5'd31);
    send_tick();                                    // tick after expiry

    in_tvalid <= 1'b0;
    for (w = 0; w < 50_000 && outstanding != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("watchdog run: %0d words checked, %0d kicks, %0d rejected creates, %0d bad ids",
             n_results, n_kicks, n_rejects, n_bad_ids);
    $display("clients registered: %0d, countdown expired: %s (%s)", n_clients,
             saw_expiry ? "yes" : "no", early_zero ? "zero reload" : "counted down");
    if (outstanding != 0)
      $display("%0t  %0d expected results never arrived", $time, outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mcw_pkg.sv
rtl/multi_client_watchdog_unit.sv
dv/mcw_checker.sv
dv/tb.sv
